/* rtl/mmab_pkg.sv */
package mmab_pkg;

  localparam int unsigned HIDDEN    = 20;
  localparam int unsigned INPUT_LEN = 10;
  localparam int unsigned ROWS      = 4 * HIDDEN;
  localparam int unsigned MAT_DEPTH = ROWS * INPUT_LEN;

  localparam int unsigned AW = $clog2(MAT_DEPTH);
  localparam int unsigned BW = $clog2(ROWS);
  localparam int unsigned KW = $clog2(INPUT_LEN);

  localparam int unsigned IDX_W  = 7;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned OUT_W  = 40;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_INPUT  = 2'd1,
    CMD_LOAD_BIAS   = 2'd2,
    CMD_QUERY       = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [OUT_W-1:0] out_value;
  } out_item_t;

  typedef struct packed {
    cmd_e                     op;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            xaddr;
    logic [BW-1:0]            bidx;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } back_state_e;

endpackage

/* rtl/mmab_front.sv */
module mmab_front
  import mmab_pkg::*;
(
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output q_entry_t push_data_o
);

  logic          row_ok;
  logic          k_ok;
  logic          col_row_ok;
  logic          keep;
  logic [AW-1:0] row_base;
  logic [AW-1:0] col_base;
  logic [AW-1:0] load_addr;

  assign row_ok     = 32'(in_data_i.row_index) < ROWS;
  assign k_ok       = 32'(in_data_i.col_index) < INPUT_LEN;
  assign col_row_ok = 32'(in_data_i.col_index) < ROWS;

  assign row_base  = AW'(32'(in_data_i.row_index) * INPUT_LEN);
  assign col_base  = AW'(32'(in_data_i.col_index) * INPUT_LEN);
  assign load_addr = AW'(32'(in_data_i.row_index) * INPUT_LEN + 32'(in_data_i.col_index));

  always_comb begin
    unique case (in_data_i.cmd) inside
      CMD_LOAD_WEIGHT, CMD_LOAD_INPUT: keep = row_ok && k_ok;
      CMD_LOAD_BIAS:                   keep = col_row_ok;
      CMD_QUERY:                       keep = row_ok && col_row_ok;
      default:                         keep = 1'b0;
    endcase
  end

  // out-of-range items are taken and dropped here
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && keep;

  always_comb begin
    push_data_o.op    = in_data_i.cmd;
    push_data_o.waddr = (in_data_i.cmd == CMD_QUERY) ? row_base : load_addr;
    push_data_o.xaddr = col_base;
    push_data_o.bidx  = BW'(in_data_i.col_index);
    push_data_o.row   = in_data_i.row_index;
    push_data_o.col   = in_data_i.col_index;
    push_data_o.value = in_data_i.value;
  end

endmodule

/* rtl/mmab_fifo.sv */
module mmab_fifo
  import mmab_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_entry_t push_data_i,
  output q_entry_t head_o,
  input  q_wr_t    wr_i,
  output q_rd_t    rd_o,
  input  logic     pop_i,
  output logic     full_o
);

  q_entry_t         mem_q [QDEPTH];
  logic [QPW-1:0]   wr_ptr_q;
  logic [QPW-1:0]   rd_ptr_q;
  logic [QCW-1:0]   cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o     = cnt_q == QCW'(QDEPTH);
  assign rd_o.empty = cnt_q == '0;
  assign rd_o.pop   = pop_i;
  assign do_push    = wr_i.push && !wr_i.full;
  assign do_pop     = pop_i && !rd_o.empty;
  assign head_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

endmodule

/* rtl/mmab_back.sv */
module mmab_back
  import mmab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_entry_t  head_i,
  input  q_rd_t     rd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic signed [DATA_W-1:0] weight_mem [MAT_DEPTH];
  logic signed [DATA_W-1:0] input_mem  [MAT_DEPTH];
  logic signed [DATA_W-1:0] bias_mem   [ROWS];

  back_state_e              state_q, state_d;
  logic [KW-1:0]            k_q;
  logic [AW-1:0]            w_addr_q;
  logic [AW-1:0]            x_addr_q;
  logic [IDX_W-1:0]         row_q;
  logic [IDX_W-1:0]         col_q;
  logic signed [DATA_W-1:0] bias_rd_q;
  logic signed [DATA_W-1:0] w_rd_q;
  logic signed [DATA_W-1:0] x_rd_q;
  logic                     rd_v_q;
  logic                     rd_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic                     prod_last_q;
  logic signed [OUT_W-1:0]  acc_q;
  logic                     out_valid_q;
  out_item_t                out_data_q;

  logic pop;
  logic issue;
  logic issue_last;
  logic out_load;

  assign pop        = (state_q == ST_IDLE) && !rd_i.empty;
  assign pop_o      = pop;
  assign issue      = state_q == ST_RUN;
  assign issue_last = k_q == KW'(INPUT_LEN - 1);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop && head_i.op == CMD_QUERY) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (prod_v_q && prod_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // stores and their read ports
  always_ff @(posedge clk_i) begin
    if (pop && head_i.op == CMD_LOAD_WEIGHT) begin
      weight_mem[head_i.waddr] <= head_i.value;
    end
    if (issue) begin
      w_rd_q <= weight_mem[w_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && head_i.op == CMD_LOAD_INPUT) begin
      input_mem[head_i.waddr] <= head_i.value;
    end
    if (issue) begin
      x_rd_q <= input_mem[x_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && head_i.op == CMD_LOAD_BIAS) begin
      bias_mem[head_i.bidx] <= head_i.value;
    end
    if (pop && head_i.op == CMD_QUERY) begin
      bias_rd_q <= bias_mem[head_i.bidx];
    end
  end

  // address walk, multiply, accumulate and output register
  always_ff @(posedge clk_i) begin
    if (pop && head_i.op == CMD_QUERY) begin
      w_addr_q <= head_i.waddr;
      x_addr_q <= head_i.xaddr;
      row_q    <= head_i.row;
      col_q    <= head_i.col;
      k_q      <= '0;
    end else if (issue) begin
      w_addr_q <= w_addr_q + AW'(1);
      x_addr_q <= x_addr_q + AW'(1);
      k_q      <= k_q + KW'(1);
    end
    rd_last_q   <= issue && issue_last;
    prod_q      <= PROD_W'(w_rd_q) * PROD_W'(x_rd_q);
    prod_last_q <= rd_last_q;
    if (issue && k_q == '0) begin
      acc_q <= {{(OUT_W - DATA_W){bias_rd_q[DATA_W-1]}}, bias_rd_q};
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(OUT_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (out_load) begin
      out_data_q.out_row   <= row_q;
      out_data_q.out_col   <= col_q;
      out_data_q.out_value <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= issue;
      prod_v_q <= rd_v_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/matrix_multiply_add_bias.sv */
// matrix product with bias, one output element per query
// in channel: in_valid_i/in_ready_o carry a command transaction (load weight,
//   load input, load bias, query); out channel: out_valid_o/out_ready_i carry
//   one result transaction per in-range query
// the front checks ranges and drops out-of-range commands, then queues the
//   rest in a two-entry queue; the back owns the three stores
// a load is written into its store when the back pops it; a query walks INPUT_LEN element pairs
//   through one multiply-accumulate unit, one read of the weight and input stores per cycle
// with the back idle, an accepted query reaches out_valid_o through the queue, the
//   pop, the element-pair reads, multiply, last add and output register; the back
//   takes no further command until the query's result is loaded into the output
//   register, so queries never overlap in the back
// commands are executed strictly in order, so loads never pass a query
// the result sits in an output register; while the receiver stalls, loads keep
//   flowing until the next query finishes, which then waits in the accumulator
//   and holds the back until the output register frees; the queue then fills
//   and in_ready_o drops
// reset clears the control state; store contents are undefined until written
module matrix_multiply_add_bias
  import mmab_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  q_entry_t push_data;
  q_entry_t head;
  q_wr_t    wr;
  q_rd_t    rd;
  logic     push;
  logic     full;
  logic     pop;

  assign wr.push = push;
  assign wr.full = full;

  mmab_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mmab_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (push_data),
    .head_o      (head),
    .wr_i        (wr),
    .rd_o        (rd),
    .pop_i       (pop),
    .full_o      (full)
  );

  mmab_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .rd_i        (rd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
